>>> sv/dpes_pkg.sv
// Package for the degree preserving edge swap block.
// Holds matrix sizes, field widths, queue depth, command and status codes, payload, queue, memory port and state types.
// No dependencies.
package dpes_pkg;

  // Matrix shape and derived widths.
  localparam int ROWS     = 64;
  localparam int COLS     = 64;
  localparam int CELLS    = ROWS * COLS;
  localparam int ADDR_W   = $clog2(CELLS);

  // Field widths fixed by the interface.
  localparam int IDX_W    = 6;
  localparam int WEIGHT_W = 32;
  localparam int CNT_W    = 24;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;

  // Depth of the queue between the front and the back.
  localparam int Q_DEPTH  = 4;
  localparam int QP_W     = $clog2(Q_DEPTH);
  localparam int QC_W     = $clog2(Q_DEPTH + 1);

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SWAP  = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_CLASH  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EDGE   = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_TARGET = 2'd3;

  // One input request.
  typedef struct packed {
    logic [CMD_W-1:0]           command;
    logic [IDX_W-1:0]           row_a;
    logic [IDX_W-1:0]           row_b;
    logic [IDX_W-1:0]           col_c;
    logic [IDX_W-1:0]           col_d;
    logic                       orientation;
    logic signed [WEIGHT_W-1:0] weight_in;
  } in_item_t;

  // One result request.
  typedef struct packed {
    logic signed [WEIGHT_W-1:0] weight_out;
    logic [STATUS_W-1:0]        status;
    logic [CNT_W-1:0]           swaps_done;
    logic                       target_reached;
  } out_item_t;

  // A classified operation as it travels from the front to the back.
  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic                range_ok;
    logic                clash;
    logic                vertical;
    logic [ADDR_W-1:0]   addr_ac;
    logic [ADDR_W-1:0]   addr_bd;
    logic [ADDR_W-1:0]   addr_ad;
    logic [ADDR_W-1:0]   addr_bc;
    logic [WEIGHT_W-1:0] weight_in;
  } op_t;

  // Memory port request from the back.
  typedef struct packed {
    logic                we;
    logic [ADDR_W-1:0]   addr;
    logic [WEIGHT_W-1:0] wdata;
  } ram_req_t;

  // Back sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_RD_WAIT,
    S_ISSUE_BD,
    S_ISSUE_AD,
    S_ISSUE_BC,
    S_CHECK,
    S_WR_AD,
    S_WR_BC,
    S_CLR_AC,
    S_CLR_BD,
    S_RESULT
  } state_t;

endpackage

>>> sv/dpes_ram.sv
// Generic single port RAM with registered read data.
// Width and depth are parameters; no package dependency.
module dpes_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read before write on the one port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> sv/dpes_front.sv
// Front of the edge swap block: accepts requests and classifies them.
// Uses dpes_pkg for the request and operation types.
module dpes_front (
  input  logic              push,
  output logic              full,
  input  dpes_pkg::in_item_t item,
  input  logic              q_full,
  output logic              q_push,
  output dpes_pkg::op_t     q_data
);

  logic range_ac;
  logic range_ad;
  logic range_bc;
  logic range_bd;
  logic idx_clash;

  // Handshake towards the sender follows the queue fill state.
  assign full   = q_full;
  assign q_push = push && !q_full;

  // Range checks on every row and column pair that a swap touches.
  always_comb begin
    range_ac = (int'(item.row_a) < dpes_pkg::ROWS) && (int'(item.col_c) < dpes_pkg::COLS);
    range_ad = (int'(item.row_a) < dpes_pkg::ROWS) && (int'(item.col_d) < dpes_pkg::COLS);
    range_bc = (int'(item.row_b) < dpes_pkg::ROWS) && (int'(item.col_c) < dpes_pkg::COLS);
    range_bd = (int'(item.row_b) < dpes_pkg::ROWS) && (int'(item.col_d) < dpes_pkg::COLS);
  end

  // Rows and columns are compared as node numbers.
  assign idx_clash = (item.row_a == item.row_b) || (item.col_c == item.col_d) ||
                     (item.row_a == item.col_d) || (item.row_b == item.col_c) ||
                     (item.row_a == item.col_c) || (item.row_b == item.col_d);

  // Build the operation with its four cell addresses.
  always_comb begin
    q_data.command   = item.command;
    q_data.range_ok  = range_ac;
    q_data.clash     = idx_clash || !range_ac || !range_ad || !range_bc || !range_bd;
    q_data.vertical  = item.orientation;
    q_data.addr_ac   = dpes_pkg::ADDR_W'(int'(item.row_a) * dpes_pkg::COLS + int'(item.col_c));
    q_data.addr_bd   = dpes_pkg::ADDR_W'(int'(item.row_b) * dpes_pkg::COLS + int'(item.col_d));
    q_data.addr_ad   = dpes_pkg::ADDR_W'(int'(item.row_a) * dpes_pkg::COLS + int'(item.col_d));
    q_data.addr_bc   = dpes_pkg::ADDR_W'(int'(item.row_b) * dpes_pkg::COLS + int'(item.col_c));
    q_data.weight_in = item.weight_in;
  end

endmodule

>>> sv/dpes_queue.sv
// Short queue of classified operations between the front and the back.
// Uses dpes_pkg for the operation type and the queue depth.
module dpes_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dpes_pkg::op_t push_data,
  output logic          full,
  input  logic          pop,
  output dpes_pkg::op_t pop_data,
  output logic          empty
);

  dpes_pkg::op_t                entries [dpes_pkg::Q_DEPTH];
  logic [dpes_pkg::QP_W-1:0]    wr_ptr;
  logic [dpes_pkg::QP_W-1:0]    rd_ptr;
  logic [dpes_pkg::QC_W-1:0]    fill;
  logic                         do_push;
  logic                         do_pop;

  assign full     = (fill == dpes_pkg::QC_W'(dpes_pkg::Q_DEPTH));
  assign empty    = (fill == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rd_ptr];

  // Pointer and fill bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == dpes_pkg::QP_W'(dpes_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == dpes_pkg::QP_W'(dpes_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

>>> sv/dpes_back.sv
// Back of the edge swap block: sequences matrix accesses and builds results.
// Uses dpes_pkg for types, codes and states; drives the matrix RAM port.
module dpes_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_empty,
  input  dpes_pkg::op_t                  q_data,
  output logic                           q_pop,
  output dpes_pkg::ram_req_t             ram_req,
  input  logic [dpes_pkg::WEIGHT_W-1:0]  ram_rdata,
  input  logic                           target_we,
  input  logic [dpes_pkg::CNT_W-1:0]     target_data,
  output logic                           empty,
  input  logic                           pop,
  output dpes_pkg::out_item_t            result
);

  dpes_pkg::state_t               state;
  dpes_pkg::state_t               state_next;
  dpes_pkg::op_t                  op;
  logic [dpes_pkg::CNT_W-1:0]     count;
  logic [dpes_pkg::CNT_W-1:0]     target;
  logic [dpes_pkg::WEIGHT_W-1:0]  wac;
  logic [dpes_pkg::WEIGHT_W-1:0]  wbd;
  logic                           ad_pos;
  logic [dpes_pkg::STATUS_W-1:0]  status;
  logic [dpes_pkg::WEIGHT_W-1:0]  wout;
  logic                           out_valid;
  logic                           reached;
  logic                           edge_fail;
  logic                           slot_free;

  // A weight is positive when it is nonzero and its sign bit is clear.
  function automatic logic is_pos(input logic [dpes_pkg::WEIGHT_W-1:0] w);
    is_pos = (w != '0) && !w[dpes_pkg::WEIGHT_W-1];
  endfunction

  assign reached   = (count >= target);
  assign edge_fail = (wac == '0) || (wbd == '0) || ad_pos || is_pos(ram_rdata);
  assign slot_free = !out_valid || pop;
  assign empty     = !out_valid;

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      dpes_pkg::S_IDLE: begin
        if (!q_empty) begin
          state_next = dpes_pkg::S_DISPATCH;
        end
      end
      dpes_pkg::S_DISPATCH: begin
        case (op.command)
          dpes_pkg::CMD_READ: begin
            state_next = op.range_ok ? dpes_pkg::S_RD_WAIT : dpes_pkg::S_RESULT;
          end
          dpes_pkg::CMD_SWAP: begin
            state_next = (reached || op.clash) ? dpes_pkg::S_RESULT : dpes_pkg::S_ISSUE_BD;
          end
          default: begin
            state_next = dpes_pkg::S_RESULT;
          end
        endcase
      end
      dpes_pkg::S_RD_WAIT:  state_next = dpes_pkg::S_RESULT;
      dpes_pkg::S_ISSUE_BD: state_next = dpes_pkg::S_ISSUE_AD;
      dpes_pkg::S_ISSUE_AD: state_next = dpes_pkg::S_ISSUE_BC;
      dpes_pkg::S_ISSUE_BC: state_next = dpes_pkg::S_CHECK;
      dpes_pkg::S_CHECK: begin
        state_next = edge_fail ? dpes_pkg::S_RESULT : dpes_pkg::S_WR_AD;
      end
      dpes_pkg::S_WR_AD:    state_next = dpes_pkg::S_WR_BC;
      dpes_pkg::S_WR_BC:    state_next = dpes_pkg::S_CLR_AC;
      dpes_pkg::S_CLR_AC:   state_next = dpes_pkg::S_CLR_BD;
      dpes_pkg::S_CLR_BD:   state_next = dpes_pkg::S_RESULT;
      dpes_pkg::S_RESULT: begin
        if (slot_free) begin
          state_next = dpes_pkg::S_IDLE;
        end
      end
      default: state_next = dpes_pkg::S_IDLE;
    endcase
  end

  // Queue pop and memory port requests for each state.
  always_comb begin
    q_pop         = 1'b0;
    ram_req.we    = 1'b0;
    ram_req.addr  = op.addr_ac;
    ram_req.wdata = '0;
    case (state)
      dpes_pkg::S_IDLE: begin
        q_pop = !q_empty;
      end
      dpes_pkg::S_DISPATCH: begin
        ram_req.addr = op.addr_ac;
        if (op.command == dpes_pkg::CMD_WRITE && op.range_ok) begin
          ram_req.we    = 1'b1;
          ram_req.wdata = op.weight_in;
        end
      end
      dpes_pkg::S_ISSUE_BD: ram_req.addr = op.addr_bd;
      dpes_pkg::S_ISSUE_AD: ram_req.addr = op.addr_ad;
      dpes_pkg::S_ISSUE_BC: ram_req.addr = op.addr_bc;
      dpes_pkg::S_WR_AD: begin
        ram_req.we    = 1'b1;
        ram_req.addr  = op.addr_ad;
        ram_req.wdata = op.vertical ? wbd : wac;
      end
      dpes_pkg::S_WR_BC: begin
        ram_req.we    = 1'b1;
        ram_req.addr  = op.addr_bc;
        ram_req.wdata = op.vertical ? wac : wbd;
      end
      dpes_pkg::S_CLR_AC: begin
        ram_req.we   = 1'b1;
        ram_req.addr = op.addr_ac;
      end
      dpes_pkg::S_CLR_BD: begin
        ram_req.we   = 1'b1;
        ram_req.addr = op.addr_bd;
      end
      default: begin
        ram_req.we = 1'b0;
      end
    endcase
  end

  // Control registers: state, swap count, target, result valid and the result itself.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dpes_pkg::S_IDLE;
      count     <= '0;
      target    <= '0;
      out_valid <= 1'b0;
      result    <= '0;
    end else begin
      state <= state_next;
      if (target_we) begin
        target <= target_data;
      end
      if (state == dpes_pkg::S_CLR_BD) begin
        count <= count + 1'b1;
      end
      if (state == dpes_pkg::S_RESULT && slot_free) begin
        out_valid             <= 1'b1;
        result.weight_out     <= wout;
        result.status         <= status;
        result.swaps_done     <= count;
        result.target_reached <= reached;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers for the operation in progress.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      op <= q_data;
    end
    case (state)
      dpes_pkg::S_DISPATCH: begin
        wout   <= '0;
        status <= dpes_pkg::STATUS_OK;
        if (op.command == dpes_pkg::CMD_SWAP) begin
          if (reached) begin
            status <= dpes_pkg::STATUS_TARGET;
          end else if (op.clash) begin
            status <= dpes_pkg::STATUS_CLASH;
          end
        end
      end
      dpes_pkg::S_RD_WAIT:  wout   <= ram_rdata;
      dpes_pkg::S_ISSUE_BD: wac    <= ram_rdata;
      dpes_pkg::S_ISSUE_AD: wbd    <= ram_rdata;
      dpes_pkg::S_ISSUE_BC: ad_pos <= is_pos(ram_rdata);
      dpes_pkg::S_CHECK: begin
        if (edge_fail) begin
          status <= dpes_pkg::STATUS_EDGE;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> sv/degree_preserving_edge_swap.sv
// Top level of the degree preserving edge swap block.
// Instantiates dpes_front, dpes_queue, dpes_back and dpes_ram; uses dpes_pkg.
//
// Requests enter through a queue-like port: an item is taken on a rising edge with push
// high and full low. Commands write or read a matrix entry, or propose a swap of the edges a-c and b-d.
// While empty is low the oldest result stands on result; it is taken on an edge with pop high.
// Exactly one result is produced per request, in request order. The user must write the swap
// target through target_we and target_data only while the block is idle; it is not enforced.
// All matrix traffic goes through one RAM port, driven by the back sequencer, which handles
// one request at a time and takes the next only after the last result is registered. A
// write or unused command goes straight to its result, as does a swap ignored for the
// target or for an index clash; a read first waits for the RAM data, a failed edge test
// ends after four reads and the check, and an applied swap takes four reads, one check and
// four writes.
// A four-entry queue lets the front keep taking requests while the back is busy or a result
// waits; full rises when it fills. If the receiver does not pop, the back holds its finished
// result and stops until the result register is free.
// Reset clears the swap count, the target, the queue and the result register. The matrix
// is not cleared: entries read before they are written hold no defined value.
module degree_preserving_edge_swap (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  dpes_pkg::in_item_t            item,
  output logic                          empty,
  input  logic                          pop,
  output dpes_pkg::out_item_t           result,
  input  logic                          target_we,
  input  logic [dpes_pkg::CNT_W-1:0]    target_data
);

  logic                           q_full;
  logic                           q_push;
  dpes_pkg::op_t                  q_wdata;
  logic                           q_empty;
  logic                           q_pop;
  dpes_pkg::op_t                  q_rdata;
  dpes_pkg::ram_req_t             ram_req;
  logic [dpes_pkg::WEIGHT_W-1:0]  ram_rdata;

  // Request acceptance and classification.
  dpes_front u_front (
    .push   (push),
    .full   (full),
    .item   (item),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  // Decoupling queue between the two halves.
  dpes_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  // Sequencer that carries out the operations.
  dpes_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_data      (q_rdata),
    .q_pop       (q_pop),
    .ram_req     (ram_req),
    .ram_rdata   (ram_rdata),
    .target_we   (target_we),
    .target_data (target_data),
    .empty       (empty),
    .pop         (pop),
    .result      (result)
  );

  // Weight matrix storage.
  dpes_ram #(
    .WIDTH (dpes_pkg::WEIGHT_W),
    .DEPTH (dpes_pkg::CELLS)
  ) u_matrix (
    .clk   (clk),
    .we    (ram_req.we),
    .addr  (ram_req.addr),
    .wdata (ram_req.wdata),
    .rdata (ram_rdata)
  );

endmodule

>>> sv/dpes_checker.sv
// Port-level checker for the degree preserving edge swap block, with its bind.
// Uses dpes_pkg for the payload types and status codes.
module dpes_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        empty,
  input logic                        pop,
  input dpes_pkg::out_item_t         result
);

  // A waiting result stays put until it is taken.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed or vanished");

  // The swap count never falls outside reset.
  a_count_monotone: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (result.swaps_done >= $past(result.swaps_done)))
    else $error("swap count decreased");

  // A swap ignored for the target must report the target as reached.
  a_target_flag: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status == dpes_pkg::STATUS_TARGET) |-> result.target_reached)
    else $error("target status without target flag");

  // A rejected swap was checked below the target, so it reports the target as not reached.
  a_reject_below: assert property (@(posedge clk) disable iff (rst)
    (!empty && (result.status == dpes_pkg::STATUS_CLASH ||
                result.status == dpes_pkg::STATUS_EDGE)) |-> !result.target_reached)
    else $error("rejected swap reported with target reached");

endmodule

bind degree_preserving_edge_swap dpes_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .empty       (empty),
  .pop         (pop),
  .result      (result)
);

>>> test/tb_top.sv
// Testbench for degree_preserving_edge_swap: matrix loads, reads and swap proposals
// are checked against a shadow copy of the matrix and the swap counter.
// Depends on dpes_pkg and the degree_preserving_edge_swap RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam logic [dpes_pkg::CMD_W-1:0] CMD_UNUSED    = 2'd3;
  localparam logic [dpes_pkg::CNT_W-1:0] CNT_MAX       = {dpes_pkg::CNT_W{1'b1}};
  localparam int                         SETTLE_CYCLES = 16;
  localparam int                         QUIET_LIMIT   = 2000;
  localparam int                         IW            = dpes_pkg::IDX_W;
  localparam int                         WW            = dpes_pkg::WEIGHT_W;
  localparam int                         AW            = dpes_pkg::ADDR_W;

  typedef enum {W_ANY, W_NONZERO, W_NONPOS} weight_shape_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       push = 1'b0;
  logic                       full;
  dpes_pkg::in_item_t         item = '0;
  logic                       empty;
  logic                       pop = 1'b0;
  dpes_pkg::out_item_t        result;
  logic                       target_we = 1'b0;
  logic [dpes_pkg::CNT_W-1:0] target_data = '0;

  // Shadow of the block's state, updated as each request is accepted.
  logic [WW-1:0]              shadow_weights [dpes_pkg::CELLS];
  logic [dpes_pkg::CNT_W-1:0] shadow_count = '0;
  logic [dpes_pkg::CNT_W-1:0] shadow_target = '0;

  // Cells that have been written, so that nothing reads an undefined entry.
  bit                         cell_written [dpes_pkg::CELLS];
  int                         written_list [$];

  dpes_pkg::out_item_t        pending_outcomes [$];
  int                         requests_sent = 0;
  int                         errors = 0;
  bit                         push_calm = 1'b0;
  bit                         pop_calm = 1'b0;
  logic [IW-1:0]              row_pool [6];
  logic [IW-1:0]              col_pool [4];

  degree_preserving_edge_swap dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .item        (item),
    .empty       (empty),
    .pop         (pop),
    .result      (result),
    .target_we   (target_we),
    .target_data (target_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] r, c);
    return AW'(int'(r) * dpes_pkg::COLS + int'(c));
  endfunction

  // Rows and columns are compared as node numbers; out-of-range indices also reject.
  function automatic bit indices_clash(input logic [IW-1:0] a, b, c, d);
    return a >= dpes_pkg::ROWS || b >= dpes_pkg::ROWS ||
           c >= dpes_pkg::COLS || d >= dpes_pkg::COLS ||
           a == b || c == d || a == d || b == c || a == c || b == d;
  endfunction

  // Applies one request to the shadow matrix and returns the result it must give.
  function automatic dpes_pkg::out_item_t rewire_step(input dpes_pkg::in_item_t req);
    dpes_pkg::out_item_t outcome;
    logic [AW-1:0]       ac, bd, ad, bc;
    logic [WW-1:0]       w_ac, w_bd;
    outcome = '0;
    ac = cell_addr(req.row_a, req.col_c);
    bd = cell_addr(req.row_b, req.col_d);
    ad = cell_addr(req.row_a, req.col_d);
    bc = cell_addr(req.row_b, req.col_c);
    case (req.command)
      dpes_pkg::CMD_WRITE: begin
        if (req.row_a < dpes_pkg::ROWS && req.col_c < dpes_pkg::COLS)
          shadow_weights[ac] = req.weight_in;
      end
      dpes_pkg::CMD_READ: begin
        if (req.row_a < dpes_pkg::ROWS && req.col_c < dpes_pkg::COLS)
          outcome.weight_out = shadow_weights[ac];
      end
      dpes_pkg::CMD_SWAP: begin
        if (shadow_count >= shadow_target) begin
          outcome.status = dpes_pkg::STATUS_TARGET;
        end else if (indices_clash(req.row_a, req.row_b, req.col_c, req.col_d)) begin
          outcome.status = dpes_pkg::STATUS_CLASH;
        end else if (shadow_weights[ac] == '0 || shadow_weights[bd] == '0 ||
                     $signed(shadow_weights[ad]) > 0 || $signed(shadow_weights[bc]) > 0) begin
          outcome.status = dpes_pkg::STATUS_EDGE;
        end else begin
          // The edges a-c and b-d move to the crossed cells and their old cells empty.
          w_ac = shadow_weights[ac];
          w_bd = shadow_weights[bd];
          shadow_weights[ac] = '0;
          shadow_weights[bd] = '0;
          if (req.orientation) begin
            shadow_weights[bc] = w_ac;
            shadow_weights[ad] = w_bd;
          end else begin
            shadow_weights[ad] = w_ac;
            shadow_weights[bc] = w_bd;
          end
          shadow_count = shadow_count + 1'b1;
          outcome.status = dpes_pkg::STATUS_OK;
        end
      end
      default: ;
    endcase
    outcome.swaps_done     = shadow_count;
    outcome.target_reached = (shadow_count >= shadow_target);
    return outcome;
  endfunction

  function automatic int draw_gap(input bit calm);
    return calm ? 0 : $urandom_range(0, 18);
  endfunction

  // Weights lean towards zero, the extremes and whole Q16.16 values.
  function automatic logic [WW-1:0] random_weight(input weight_shape_t shape);
    logic [WW-1:0] w;
    case ($urandom_range(0, 5))
      0:       w = '0;
      1:       w = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      2, 3:    w = $urandom;
      4:       w = {8'h00, 8'($urandom_range(1, 255)), 16'h0000};
      default: w = -{8'h00, 8'($urandom_range(1, 255)), 16'h0000};
    endcase
    if (shape == W_NONZERO && w == '0) w = 32'h0001_0000;
    if (shape == W_NONPOS && w != '0 && !w[WW-1]) w = -w;
    return w;
  endfunction

  function automatic dpes_pkg::in_item_t make_request(
      input logic [dpes_pkg::CMD_W-1:0] cmd,
      input logic [IW-1:0] a, b, c, d,
      input logic o,
      input logic [WW-1:0] w);
    dpes_pkg::in_item_t req;
    req.command     = cmd;
    req.row_a       = a;
    req.row_b       = b;
    req.col_c       = c;
    req.col_d       = d;
    req.orientation = o;
    req.weight_in   = w;
    return req;
  endfunction

  function automatic logic [IW-1:0] rand_idx();
    return IW'($urandom);
  endfunction

  // Sends one request after a random gap; push stays high into the next request.
  task automatic push_request(input dpes_pkg::in_item_t req);
    int gap;
    gap = draw_gap(push_calm);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    item <= req;
    do @(posedge clk); while (full !== 1'b0);
    pending_outcomes = {pending_outcomes, rewire_step(req)};
    requests_sent++;
  endtask

  task automatic write_entry(input logic [IW-1:0] r, c, input logic [WW-1:0] w);
    if (!cell_written[cell_addr(r, c)]) begin
      cell_written[cell_addr(r, c)] = 1'b1;
      written_list = {written_list, int'(cell_addr(r, c))};
    end
    push_request(make_request(dpes_pkg::CMD_WRITE, r, rand_idx(), c, rand_idx(),
                              1'($urandom), w));
  endtask

  task automatic read_entry(input logic [IW-1:0] r, c);
    push_request(make_request(dpes_pkg::CMD_READ, r, rand_idx(), c, rand_idx(),
                              1'($urandom), $urandom));
  endtask

  // A swap that will look at the matrix first has any blank cell of its four loaded.
  task automatic propose_swap(input logic [IW-1:0] a, b, c, d, input logic o);
    if (shadow_count < shadow_target && !indices_clash(a, b, c, d)) begin
      if (!cell_written[cell_addr(a, c)]) write_entry(a, c, random_weight(W_ANY));
      if (!cell_written[cell_addr(b, d)]) write_entry(b, d, random_weight(W_ANY));
      if (!cell_written[cell_addr(a, d)]) write_entry(a, d, random_weight(W_ANY));
      if (!cell_written[cell_addr(b, c)]) write_entry(b, c, random_weight(W_ANY));
    end
    push_request(make_request(dpes_pkg::CMD_SWAP, a, b, c, d, o, $urandom));
  endtask

  // A swap on the node pools, with none, some or all of its cells set up to pass.
  task automatic staged_swap(input bit full_setup);
    int            i, j, k, m;
    logic [IW-1:0] a, b, c, d;
    i = $urandom_range(0, 5);
    j = (i + $urandom_range(1, 5)) % 6;
    k = $urandom_range(0, 3);
    m = (k + $urandom_range(1, 3)) % 4;
    a = row_pool[3'(i)];
    b = row_pool[3'(j)];
    c = col_pool[2'(k)];
    d = col_pool[2'(m)];
    if (full_setup || $urandom_range(0, 1)) write_entry(a, c, random_weight(W_NONZERO));
    if (full_setup || $urandom_range(0, 1)) write_entry(b, d, random_weight(W_NONZERO));
    if (full_setup || $urandom_range(0, 1)) write_entry(a, d, random_weight(W_NONPOS));
    if (full_setup || $urandom_range(0, 1)) write_entry(b, c, random_weight(W_NONPOS));
    propose_swap(a, b, c, d, 1'($urandom_range(0, 1)));
  endtask

  // Waits until every result has been taken and the block has gone quiet.
  task automatic drain_outcomes();
    push <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_swap_target(input logic [dpes_pkg::CNT_W-1:0] value);
    drain_outcomes();
    target_we   <= 1'b1;
    target_data <= value;
    @(posedge clk);
    target_we     <= 1'b0;
    shadow_target  = value;
  endtask

  // With a target of zero every swap is ignored, while loads and reads still work.
  task automatic test_target_zero();
    load_swap_target('0);
    write_entry(0, 0, 32'h8000_0000);
    read_entry(0, 0);
    propose_swap(0, 63, 1, 62, 1'b1);
    push_request(make_request(CMD_UNUSED, rand_idx(), rand_idx(), rand_idx(), rand_idx(),
                              1'($urandom), $urandom));
  endtask

  // Each edge rule, both orientations and every kind of index clash on one quad.
  task automatic test_swap_rules();
    load_swap_target(CNT_MAX);
    write_entry(63, 0, '0);
    write_entry(2, 61, 32'h7FFF_FFFF);
    write_entry(63, 61, 32'h8000_0000);
    write_entry(2, 0, '0);
    propose_swap(63, 2, 0, 61, 1'b0);
    // Edge a-c is now present but b-d is missing.
    write_entry(63, 0, 32'h0001_0000);
    write_entry(2, 61, '0);
    propose_swap(63, 2, 0, 61, 1'b0);
    // Both edges present, but a-d is positive.
    write_entry(2, 61, 32'h7FFF_FFFF);
    write_entry(63, 61, 32'h0000_0001);
    propose_swap(63, 2, 0, 61, 1'b1);
    // A negative a-d is allowed; a positive b-c is not.
    write_entry(63, 61, 32'h8000_0000);
    write_entry(2, 0, 32'h0000_0001);
    propose_swap(63, 2, 0, 61, 1'b0);
    write_entry(2, 0, '0);
    propose_swap(63, 2, 0, 61, 1'b0);
    read_entry(63, 61);
    propose_swap(63, 2, 61, 0, 1'b1);
    read_entry(2, 61);
    // Clashing indices, one kind at a time.
    propose_swap(63, 63, 0, 61, 1'b0);
    propose_swap(63, 2, 0, 0, 1'b1);
    propose_swap(63, 2, 0, 63, 1'b0);
    propose_swap(63, 2, 2, 61, 1'b1);
    propose_swap(63, 2, 63, 61, 1'b0);
    propose_swap(63, 2, 0, 2, 1'b1);
  endtask

  // Mostly swaps on a small set of nodes, many of them staged, mixed with noise of every kind.
  task automatic test_random_mix();
    int            k, stop_at, pick, r;
    logic [IW-1:0] a, b, c, d;
    logic          o;
    row_pool[0] = '0;
    row_pool[1] = IW'(dpes_pkg::ROWS - 1);
    for (k = 0; k < 4; k++) begin
      row_pool[3'(k + 2)] = IW'(8 * k + $urandom_range(1, 7));
      col_pool[2'(k)]     = IW'(32 + 8 * k + $urandom_range(0, 6));
    end
    stop_at = requests_sent + 430;
    while (requests_sent < stop_at) begin
      if ($urandom_range(0, 39) == 0) begin
        push_calm = ($urandom_range(0, 2) == 0);
        pop_calm  = ($urandom_range(0, 2) == 0);
      end
      pick = $urandom_range(0, 99);
      a = rand_idx();
      b = rand_idx();
      c = rand_idx();
      d = rand_idx();
      o = 1'($urandom);
      if (pick < 45) begin
        staged_swap(1'b0);
      end else if (pick < 58) begin
        propose_swap(row_pool[3'($urandom_range(0, 5))], row_pool[3'($urandom_range(0, 5))],
                     col_pool[2'($urandom_range(0, 3))], col_pool[2'($urandom_range(0, 3))],
                     o);
      end else if (pick < 64) begin
        propose_swap(a, b, c, d, o);
      end else if (pick < 72) begin
        case ($urandom_range(0, 5))
          0:       b = a;
          1:       d = c;
          2:       d = a;
          3:       c = b;
          4:       c = a;
          default: d = b;
        endcase
        propose_swap(a, b, c, d, o);
      end else if (pick < 84) begin
        write_entry(a, c, random_weight(W_ANY));
      end else if (pick < 97) begin
        // Pool cells show the effect of swaps; other cells only loads.
        a = row_pool[3'($urandom_range(0, 5))];
        c = col_pool[2'($urandom_range(0, 3))];
        if (!cell_written[cell_addr(a, c)] || $urandom_range(0, 2) == 0) begin
          r = written_list[$urandom_range(0, written_list.size() - 1)];
          a = IW'(r / dpes_pkg::COLS);
          c = IW'(r % dpes_pkg::COLS);
        end
        read_entry(a, c);
      end else begin
        push_request(make_request(CMD_UNUSED, a, b, c, d, o, $urandom));
      end
    end
    push_calm = 1'b0;
    pop_calm  = 1'b0;
  endtask

  // A small target is met by passing swaps, after which proposals are ignored.
  task automatic test_target_reach();
    int n;
    load_swap_target(dpes_pkg::CNT_W'(shadow_count + 3));
    while (shadow_count < shadow_target) staged_swap(1'b1);
    for (n = 0; n < 10; n++) begin
      if (n % 2) staged_swap(1'b0);
      else read_entry(row_pool[3'($urandom_range(0, 1))], col_pool[2'($urandom_range(0, 3))]);
    end
  endtask

  // Takes results after random stalls and compares each with the oldest expectation.
  initial begin : outcome_checker
    int                  stall;
    dpes_pkg::out_item_t want;
    while (rst) @(posedge clk);
    forever begin
      stall = draw_gap(pop_calm);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty !== 1'b0);
      if (pending_outcomes.size() == 0) begin
        $error("result with no request outstanding: status %0d", result.status);
        errors++;
      end else begin
        want = pending_outcomes.pop_front();
        if (result.weight_out !== want.weight_out) begin
          $error("weight_out: expected %h, got %h", want.weight_out, result.weight_out);
          errors++;
        end
        if (result.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result.status);
          errors++;
        end
        if (result.swaps_done !== want.swaps_done) begin
          $error("swaps_done: expected %0d, got %0d", want.swaps_done, result.swaps_done);
          errors++;
        end
        if (result.target_reached !== want.target_reached) begin
          $error("target_reached: expected %0b, got %0b",
                 want.target_reached, result.target_reached);
          errors++;
        end
      end
    end
  end

  // Ends the run if no request moves on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin : run_tests
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_target_zero();
    test_swap_rules();
    test_random_mix();
    test_target_reach();
    drain_outcomes();
    if (errors == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule
